// File: design/ssc_pkg.sv
// package for the sensorless six-step commutator
// holds field widths, register index codes and sector-to-phase tables
// no dependencies
package ssc_pkg;

  localparam int ADC_BITS_DEF = 12;
  localparam int PWM_BITS     = 16;
  localparam int CMD_W        = 16;
  localparam int SPEED_W      = 16;
  localparam int DUTY_W       = 16;
  localparam int SEC_W        = 3;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int MINCMD_W     = 15;

  localparam int OUT_FIELDS_W = SEC_W + 3 * DUTY_W + 3;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // duties keep at most PWM_BITS bits
  localparam int DUTY_KEEP = (PWM_BITS < DUTY_W) ? PWM_BITS : DUTY_W;
  localparam logic [DUTY_W-1:0] DUTY_MASK = DUTY_W'((64'd1 << DUTY_KEEP) - 64'd1);

  localparam logic [MINCMD_W-1:0] HALF_Q14 = MINCMD_W'(16384);

  typedef logic [SEC_W-1:0] sector_t;
  typedef logic [1:0]       phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FULL_DUTY   = 2'd0,
    CFG_LOW_SPEED   = 2'd1,
    CFG_MIN_COMMAND = 2'd2,
    CFG_FORCED_TICKS = 2'd3
  } cfg_idx_t;

  localparam phase_t PH_A = 2'd0;
  localparam phase_t PH_B = 2'd1;
  localparam phase_t PH_C = 2'd2;

  // sectors AB AC BC BA CA CB: high phase, low phase, floating phase
  function automatic phase_t high_of(input sector_t s);
    phase_t p;
    unique case (s)
      3'd0, 3'd1: p = PH_A;
      3'd2, 3'd3: p = PH_B;
      3'd4, 3'd5: p = PH_C;
      default:    p = PH_A;
    endcase
    return p;
  endfunction

  function automatic phase_t low_of(input sector_t s);
    phase_t p;
    unique case (s)
      3'd0, 3'd5: p = PH_B;
      3'd1, 3'd2: p = PH_C;
      3'd3, 3'd4: p = PH_A;
      default:    p = PH_B;
    endcase
    return p;
  endfunction

  function automatic phase_t float_of(input sector_t s);
    phase_t p;
    unique case (s)
      3'd0, 3'd3: p = PH_C;
      3'd1, 3'd4: p = PH_B;
      3'd2, 3'd5: p = PH_A;
      default:    p = PH_C;
    endcase
    return p;
  endfunction

endpackage

// File: design/sensorless_six_step_commutator_unit.sv
// top level of the sensorless six-step commutator
// back-emf crossing detect, forced stepping, sector wrap and phase duties
// depends on ssc_pkg
//
// channel  dir  handshake          payload
// in_      in   tvalid/tready      command, neutral, phase a/b/c volts, speed
// out_     out  tvalid/tready      sector, duty a/b/c, enable a/b/c
// cfg_     in   we (no wait)       index + write data, four registers
//
// one request per clock sustained while the result side accepts; a request passes
// from accept to result through the input register, then the result register
// the sector, forced counter and held duties update as the result is formed,
// so each request sees the state left by the one before it
// reset (rst_n low, synchronous) empties both stages and restores the state
// and register defaults; a stalled result holds and the input stage keeps
// accepting as long as the result register can drain
module sensorless_six_step_commutator_unit #(
  parameter int ADC_BITS = ssc_pkg::ADC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // in_tdata low to high: command, neutral_volts, phase_a_volts,
  // phase_b_volts, phase_c_volts, speed_mag, zero fill
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [((ssc_pkg::CMD_W + 4*ADC_BITS + ssc_pkg::SPEED_W + 7)/8)*8-1:0]
                                                 in_tdata,
  // out_tdata low to high: sector_now, duty_a, duty_b, duty_c,
  // enable_a, enable_b, enable_c, zero fill
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [ssc_pkg::OUT_TDATA_W-1:0]        out_tdata,
  input  logic                                   cfg_we,
  input  logic [ssc_pkg::CFG_IDX_W-1:0]          cfg_addr,
  input  logic [ssc_pkg::CFG_DATA_W-1:0]         cfg_wdata
);
  import ssc_pkg::*;

  localparam int IN_FIELDS_W = CMD_W + 4 * ADC_BITS + SPEED_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int NEU_LO = CMD_W;
  localparam int PA_LO  = NEU_LO + ADC_BITS;
  localparam int PB_LO  = PA_LO + ADC_BITS;
  localparam int PC_LO  = PB_LO + ADC_BITS;
  localparam int SPD_LO = PC_LO + ADC_BITS;

  // configuration registers
  logic [DUTY_W-1:0]   full_duty_r;
  logic [SPEED_W-1:0]  low_speed_r;
  logic [MINCMD_W-1:0] min_cmd_r;
  logic [15:0]         forced_ticks_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_duty_r    <= DUTY_W'(1000);
      low_speed_r    <= SPEED_W'(100);
      min_cmd_r      <= MINCMD_W'(1638);
      forced_ticks_r <= 16'd5000;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_FULL_DUTY:    full_duty_r    <= cfg_wdata[DUTY_W-1:0];
        CFG_LOW_SPEED:    low_speed_r    <= cfg_wdata[SPEED_W-1:0];
        CFG_MIN_COMMAND:  min_cmd_r      <= cfg_wdata[MINCMD_W-1:0];
        CFG_FORCED_TICKS: forced_ticks_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // input register stage
  logic                  in_vld_r;
  logic [IN_TDATA_W-1:0] in_dat_r;
  logic                  out_vld_r;
  logic [OUT_TDATA_W-1:0] out_dat_r;
  logic                  advance;

  assign advance   = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_dat_r <= in_tdata;
    end
  end

  // unpack the registered request
  logic [CMD_W-1:0]    cmd_raw;
  logic [ADC_BITS-1:0] neu_v, pa_v, pb_v, pc_v, flt_v;
  logic [SPEED_W-1:0]  speed;

  assign cmd_raw = in_dat_r[CMD_W-1:0];
  assign neu_v   = in_dat_r[NEU_LO +: ADC_BITS];
  assign pa_v    = in_dat_r[PA_LO +: ADC_BITS];
  assign pb_v    = in_dat_r[PB_LO +: ADC_BITS];
  assign pc_v    = in_dat_r[PC_LO +: ADC_BITS];
  assign speed   = in_dat_r[SPD_LO +: SPEED_W];

  // state
  sector_t           sector_r, sector_nxt;
  logic [15:0]       fcnt_r, fcnt_nxt;
  logic [DUTY_W-1:0] held_r   [3];
  logic [DUTY_W-1:0] held_nxt [3];

  // command sign and magnitude; -32768 gives 32768, which fits 16 bits
  logic              neg;
  logic [CMD_W-1:0]  mag;
  assign neg = cmd_raw[CMD_W-1];
  assign mag = neg ? (CMD_W'(0) - cmd_raw) : cmd_raw;

  // back-emf crossing on the floating phase
  logic up_x, down_x, ge_n, le_n;
  always_comb begin
    unique case (float_of(sector_r))
      PH_A:    flt_v = pa_v;
      PH_B:    flt_v = pb_v;
      default: flt_v = pc_v;
    endcase
    ge_n = flt_v >= neu_v;
    le_n = flt_v <= neu_v;
    // even sectors see a rising floating phase when turning forward
    if (!sector_r[0]) begin
      up_x   = ge_n;
      down_x = le_n;
    end else begin
      up_x   = le_n;
      down_x = ge_n;
    end
  end

  // forced stepping at low speed; counter holds when not qualified
  logic        force_ok, force_step;
  logic [16:0] fcnt_inc;
  always_comb begin
    force_ok   = (speed <= low_speed_r) && (mag >= {1'b0, min_cmd_r});
    fcnt_inc   = {1'b0, fcnt_r} + 17'd1;
    force_step = force_ok && (fcnt_inc >= {1'b0, forced_ticks_r});
    fcnt_nxt   = fcnt_r;
    if (force_ok) begin
      fcnt_nxt = force_step ? 16'd0 : fcnt_inc[15:0];
    end
  end

  // sector: both steps in a 4-bit signed sum, then wrap into 0..5
  logic signed [3:0] sec_sum;
  always_comb begin
    sec_sum = signed'({1'b0, sector_r});
    if (!neg && up_x) begin
      sec_sum = sec_sum + 4'sd1;
    end else if (neg && down_x) begin
      sec_sum = sec_sum - 4'sd1;
    end
    if (force_step) begin
      sec_sum = neg ? (sec_sum - 4'sd1) : (sec_sum + 4'sd1);
    end
    priority if (sec_sum < 4'sd0) begin
      sector_nxt = 3'd5;
    end else if (sec_sum > 4'sd5) begin
      sector_nxt = 3'd0;
    end else begin
      sector_nxt = sec_sum[SEC_W-1:0];
    end
  end

  // duties: full * (half +/- m) / 2^15 with m saturated to half
  logic [MINCMD_W-1:0] m_sat;
  logic [15:0]         hi_fac;
  logic [MINCMD_W-1:0] lo_fac;
  logic [31:0]         hi_prod, lo_prod;
  logic [DUTY_W-1:0]   hi_duty, lo_duty;
  phase_t              hi_ph, lo_ph, fl_ph;

  always_comb begin
    m_sat   = (mag > {1'b0, HALF_Q14}) ? HALF_Q14 : mag[MINCMD_W-1:0];
    hi_fac  = {1'b0, HALF_Q14} + {1'b0, m_sat};
    lo_fac  = HALF_Q14 - m_sat;
    hi_prod = 32'(full_duty_r) * 32'(hi_fac);
    lo_prod = 32'(full_duty_r) * 32'(lo_fac);
    hi_duty = hi_prod[30:15] & DUTY_MASK;
    lo_duty = lo_prod[30:15] & DUTY_MASK;
    hi_ph   = high_of(sector_nxt);
    lo_ph   = low_of(sector_nxt);
    fl_ph   = float_of(sector_nxt);
    for (int k = 0; k < 3; k++) begin
      // floating phase keeps its last duty
      if (phase_t'(k) == hi_ph) begin
        held_nxt[k] = hi_duty;
      end else if (phase_t'(k) == lo_ph) begin
        held_nxt[k] = lo_duty;
      end else begin
        held_nxt[k] = held_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sector_r <= '0;
      fcnt_r   <= '0;
      for (int k = 0; k < 3; k++) begin
        held_r[k] <= '0;
      end
    end else if (advance) begin
      sector_r <= sector_nxt;
      fcnt_r   <= fcnt_nxt;
      for (int k = 0; k < 3; k++) begin
        held_r[k] <= held_nxt[k];
      end
    end
  end

  // result register
  logic [OUT_TDATA_W-1:0] out_pack;
  always_comb begin
    out_pack = '0;
    out_pack[SEC_W-1:0]                    = sector_nxt;
    out_pack[SEC_W +: DUTY_W]              = held_nxt[0];
    out_pack[SEC_W + DUTY_W +: DUTY_W]     = held_nxt[1];
    out_pack[SEC_W + 2*DUTY_W +: DUTY_W]   = held_nxt[2];
    out_pack[SEC_W + 3*DUTY_W]             = (fl_ph != PH_A);
    out_pack[SEC_W + 3*DUTY_W + 1]         = (fl_ph != PH_B);
    out_pack[SEC_W + 3*DUTY_W + 2]         = (fl_ph != PH_C);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_dat_r <= out_pack;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_dat_r;

endmodule

// File: tb/sv/tb_top.sv
// self-checking testbench for sensorless_six_step_commutator_unit
// directed table then random control ticks, checked against an in-bench commutation predictor
// depends on ssc_pkg and the commutator rtl
`timescale 1ns / 100ps

module tb_top;
  import ssc_pkg::*;

  localparam int ADC_W       = ADC_BITS_DEF;
  localparam int IN_W        = ((CMD_W + 4 * ADC_W + SPEED_W + 7) / 8) * 8;
  localparam int PIPE_LAT    = 2;        // input register plus result register
  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PCT    = 37;
  localparam int PHASES      = 7;
  localparam int PHASE_TICKS = 200;
  localparam logic [16:0] Q14_ONE = 17'd16384;

  // sectors AB AC BC BA CA CB: driven-high, driven-low and floating phase
  localparam phase_t HIGH_PH  [6] = '{PH_A, PH_A, PH_B, PH_B, PH_C, PH_C};
  localparam phase_t LOW_PH   [6] = '{PH_B, PH_C, PH_C, PH_A, PH_A, PH_B};
  localparam phase_t FLOAT_PH [6] = '{PH_C, PH_B, PH_A, PH_C, PH_B, PH_A};

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [ADC_W-1:0]   neutral;
    logic [ADC_W-1:0]   va;
    logic [ADC_W-1:0]   vb;
    logic [ADC_W-1:0]   vc;
    logic [SPEED_W-1:0] speed;
  } tick_in_t;

  typedef struct packed {
    sector_t           sector;
    logic [DUTY_W-1:0] duty_a;
    logic [DUTY_W-1:0] duty_b;
    logic [DUTY_W-1:0] duty_c;
    logic              en_a;
    logic              en_b;
    logic              en_c;
  } drive_out_t;

  typedef enum bit {ROW_TICK, ROW_CFG} row_kind_t;

  // one line of the directed table: either a register write or a tick,
  // a tick optionally carrying a hand-typed expected drive
  typedef struct packed {
    row_kind_t             kind;
    cfg_idx_t              reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    tick_in_t              tick;
    bit                    typed;
    drive_out_t            want;
  } stim_row_t;

  localparam int DIR_ROWS = 33;
  localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
    // after reset, zero command, everything at zero: float C crosses, step to AC, half duty
    '{ROW_TICK, CFG_FULL_DUTY, 16'h0000,
      '{16'h0000, 12'h000, 12'h000, 12'h000, 12'h000, 16'hFFFF}, 1'b1,
      '{3'd1, 16'd500, 16'd0, 16'd500, 1'b1, 1'b0, 1'b1}},
    // full positive command, float B at neutral: step to BC, B full, C zero
    '{ROW_TICK, CFG_FULL_DUTY, 16'h0000,
      '{16'h4000, 12'h000, 12'h000, 12'h000, 12'h000, 16'hFFFF}, 1'b1,
      '{3'd2, 16'd500, 16'd1000, 16'd0, 1'b0, 1'b1, 1'b1}},
    // most negative command saturates: step back to AC, A full, B holds
    '{ROW_TICK, CFG_FULL_DUTY, 16'h0000,
      '{16'h8000, 12'h000, 12'h000, 12'h000, 12'h000, 16'hFFFF}, 1'b1,
      '{3'd1, 16'd1000, 16'd1000, 16'd0, 1'b1, 1'b0, 1'b1}},
    // largest positive command, all inputs at full scale
    '{ROW_TICK, CFG_FULL_DUTY, 16'h0000,
      '{16'h7FFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 16'hFFFF}, 1'b0, '0},
    // low speed, enough command: forced counter starts
    '{ROW_TICK, CFG_FULL_DUTY, 16'h0000,
      '{16'h2000, 12'h800, 12'h000, 12'hFFF, 12'h7FF, 16'h0000}, 1'b0, '0},
    // equal voltages always cross: walk up through the 5 to 0 wrap
    '{ROW_TICK, CFG_FULL_DUTY, 16'h0000,
      '{16'h2000, 12'h555, 12'h555, 12'h555, 12'h555, 16'hFFFF}, 1'b0, '0},
    '{ROW_TICK, CFG_FULL_DUTY, 16'h0000,
      '{16'h2000, 12'h555, 12'h555, 12'h555, 12'h555, 16'hFFFF}, 1'b0, '0},
    '{ROW_TICK, CFG_FULL_DUTY, 16'h0000,
      '{16'h2000, 12'h555, 12'h555, 12'h555, 12'h555, 16'hFFFF}, 1'b0, '0},
    '{ROW_TICK, CFG_FULL_DUTY, 16'h0000,
      '{16'h2000, 12'h555, 12'h555, 12'h555, 12'h555, 16'hFFFF}, 1'b0, '0},
    '{ROW_TICK, CFG_FULL_DUTY, 16'h0000,
      '{16'h2000, 12'h555, 12'h555, 12'h555, 12'h555, 16'hFFFF}, 1'b0, '0},
    // negative direction: walk down through the 0 to 5 wrap
    '{ROW_TICK, CFG_FULL_DUTY, 16'h0000,
      '{16'hE000, 12'hAAA, 12'hAAA, 12'hAAA, 12'hAAA, 16'hFFFF}, 1'b0, '0},
    '{ROW_TICK, CFG_FULL_DUTY, 16'h0000,
      '{16'hE000, 12'hAAA, 12'hAAA, 12'hAAA, 12'hAAA, 16'hFFFF}, 1'b0, '0},
    '{ROW_TICK, CFG_FULL_DUTY, 16'h0000,
      '{16'hE000, 12'hAAA, 12'hAAA, 12'hAAA, 12'hAAA, 16'hFFFF}, 1'b0, '0},
    // speed at and just below the limit, command below minimum
    '{ROW_TICK, CFG_FULL_DUTY, 16'h0000,
      '{16'hFFFF, 12'h800, 12'h000, 12'hFFF, 12'h4D2, 16'd100}, 1'b0, '0},
    '{ROW_TICK, CFG_FULL_DUTY, 16'h0000,
      '{16'h0001, 12'hFFF, 12'hFFF, 12'h000, 12'h000, 16'd99}, 1'b0, '0},
    // zero forced-step ticks: every qualifying tick takes a forced step, so these crossing ticks step twice
    '{ROW_CFG, CFG_FORCED_TICKS, 16'h0000, '0, 1'b0, '0},
    '{ROW_CFG, CFG_LOW_SPEED, 16'hFFFF, '0, 1'b0, '0},
    '{ROW_CFG, CFG_MIN_COMMAND, 16'h0000, '0, 1'b0, '0},
    '{ROW_TICK, CFG_FULL_DUTY, 16'h0000,
      '{16'h0000, 12'h123, 12'h123, 12'h123, 12'h123, 16'hFFFF}, 1'b0, '0},
    '{ROW_TICK, CFG_FULL_DUTY, 16'h0000,
      '{16'h0000, 12'h123, 12'h123, 12'h123, 12'h123, 16'hFFFF}, 1'b0, '0},
    '{ROW_TICK, CFG_FULL_DUTY, 16'h0000,
      '{16'h0000, 12'h123, 12'h123, 12'h123, 12'h123, 16'hFFFF}, 1'b0, '0},
    '{ROW_TICK, CFG_FULL_DUTY, 16'h0000,
      '{16'hC000, 12'h321, 12'h321, 12'h321, 12'h321, 16'hFFFF}, 1'b0, '0},
    '{ROW_TICK, CFG_FULL_DUTY, 16'h0000,
      '{16'hC000, 12'h321, 12'h321, 12'h321, 12'h321, 16'hFFFF}, 1'b0, '0},
    // largest full duty
    '{ROW_CFG, CFG_FULL_DUTY, 16'hFFFF, '0, 1'b0, '0},
    '{ROW_TICK, CFG_FULL_DUTY, 16'h0000,
      '{16'h4000, 12'h400, 12'h3FF, 12'h401, 12'h7FF, 16'h0001}, 1'b0, '0},
    '{ROW_TICK, CFG_FULL_DUTY, 16'h0000,
      '{16'h0000, 12'h000, 12'hFFF, 12'hFFF, 12'hFFF, 16'h8000}, 1'b0, '0},
    // zero full duty, forced step every qualifying tick, minimum command at full scale
    '{ROW_CFG, CFG_FULL_DUTY, 16'h0000, '0, 1'b0, '0},
    '{ROW_CFG, CFG_FORCED_TICKS, 16'h0001, '0, 1'b0, '0},
    '{ROW_CFG, CFG_MIN_COMMAND, 16'h4000, '0, 1'b0, '0},
    '{ROW_CFG, CFG_LOW_SPEED, 16'h0000, '0, 1'b0, '0},
    '{ROW_TICK, CFG_FULL_DUTY, 16'h0000,
      '{16'hC000, 12'h000, 12'h000, 12'h000, 12'h000, 16'h0000}, 1'b0, '0},
    '{ROW_TICK, CFG_FULL_DUTY, 16'h0000,
      '{16'h3FFF, 12'h000, 12'h000, 12'h000, 12'h000, 16'h0000}, 1'b0, '0},
    '{ROW_TICK, CFG_FULL_DUTY, 16'h0000,
      '{16'h8000, 12'h000, 12'h000, 12'h000, 12'h000, 16'h0001}, 1'b0, '0}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // in_tdata low to high: command, neutral_volts, phase_a_volts,
  // phase_b_volts, phase_c_volts, speed_mag
  logic [IN_W-1:0]       in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // out_tdata low to high: sector_now, duty_a, duty_b, duty_c,
  // enable_a, enable_b, enable_c, zero fill
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                  cfg_we = 1'b0;
  cfg_idx_t              cfg_addr = CFG_FULL_DUTY;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // predictor copy of the registers, reset values
  logic [15:0]           full_duty_r  = 16'd1000;
  logic [15:0]           speed_lim_r  = 16'd100;
  logic [MINCMD_W-1:0]   min_cmd_r    = 15'd1638;
  logic [15:0]           step_ticks_r = 16'd5000;

  // predictor copy of the commutation state
  sector_t               sector_q = '0;
  logic [15:0]           force_cnt = '0;
  logic [DUTY_W-1:0]     held_duty [3] = '{default: '0};

  drive_out_t            pending_drive [$];   // expected drive per accepted request
  drive_out_t            want_drive;
  int unsigned           mismatch_cnt = 0;
  int unsigned           cycle_cnt = 0;
  bit                    no_gaps = 1'b0;

  sensorless_six_step_commutator_unit #(
    .ADC_BITS (ADC_W)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // one control tick: back-emf crossing step, forced step, wrap, then duties
  function automatic drive_out_t commutate(input tick_in_t t);
    logic        neg;
    logic [16:0] mag;
    logic [16:0] sat;
    logic [11:0] fv;
    logic        up;
    logic        down;
    logic [16:0] cnt;
    logic [63:0] hi;
    logic [63:0] lo;
    int          sec;
    drive_out_t  r;
    neg = t.cmd[15];
    mag = neg ? (17'h10000 - {1'b0, t.cmd}) : {1'b0, t.cmd};
    sec = int'(sector_q);
    // compare the floating phase with neutral
    case (FLOAT_PH[sec])
      PH_A: fv = t.va;
      PH_B: fv = t.vb;
      default: fv = t.vc;
    endcase
    // even sectors see a rising crossing going forward, odd sectors a falling one
    if (sec % 2 == 0) begin
      up   = fv >= t.neutral;
      down = fv <= t.neutral;
    end else begin
      up   = fv <= t.neutral;
      down = fv >= t.neutral;
    end
    if (!neg && up) begin
      sec = sec + 1;
    end else if (neg && down) begin
      sec = sec - 1;
    end
    // forced stepping counts only while qualified, holds otherwise
    if (t.speed <= speed_lim_r && mag >= {2'b00, min_cmd_r}) begin
      cnt = {1'b0, force_cnt} + 17'd1;
      if (cnt >= {1'b0, step_ticks_r}) begin
        sec = neg ? sec - 1 : sec + 1;
        cnt = '0;
      end
      force_cnt = cnt[15:0];
    end
    if (sec < 0) begin
      sec = 5;
    end else if (sec > 5) begin
      sec = 0;
    end
    sector_q = sector_t'(sec);
    sat = (mag > Q14_ONE) ? Q14_ONE : mag;
    hi = (64'(full_duty_r) * 64'(Q14_ONE + sat)) >> 15;
    lo = (64'(full_duty_r) * 64'(Q14_ONE - sat)) >> 15;
    held_duty[HIGH_PH[sec]] = hi[DUTY_W-1:0] & DUTY_MASK;
    held_duty[LOW_PH[sec]]  = lo[DUTY_W-1:0] & DUTY_MASK;
    r.sector = sector_q;
    r.duty_a = held_duty[PH_A];
    r.duty_b = held_duty[PH_B];
    r.duty_c = held_duty[PH_C];
    r.en_a   = FLOAT_PH[sec] != PH_A;
    r.en_b   = FLOAT_PH[sec] != PH_B;
    r.en_c   = FLOAT_PH[sec] != PH_C;
    return r;
  endfunction

  // random tick; most follow a run of one direction, some are pure noise
  function automatic tick_in_t random_tick(input bit run_neg, input bit noise);
    tick_in_t    t;
    logic [15:0] mag;
    t.neutral = 12'($urandom);
    t.va      = 12'($urandom);
    t.vb      = 12'($urandom);
    t.vc      = 12'($urandom);
    if (noise) begin
      t.cmd = 16'($urandom);
    end else begin
      case ($urandom_range(0, 5))
        0: mag = 16'h4000;
        1: mag = 16'($urandom_range(16385, 32767));
        2: mag = 16'(min_cmd_r);
        3: mag = 16'($urandom_range(0, 64));
        default: mag = 16'($urandom_range(0, 16384));
      endcase
      t.cmd = run_neg ? (16'd0 - mag) : mag;
    end
    // equal voltages and rail values hit the inclusive compares
    case ($urandom_range(0, 5))
      0: begin
        t.va = t.neutral;
        t.vb = t.neutral;
        t.vc = t.neutral;
      end
      1: t.neutral = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
      default: ;
    endcase
    if ($urandom_range(0, 1) == 1) begin
      t.speed = 16'($urandom_range(0, int'(speed_lim_r)));
    end else begin
      t.speed = 16'($urandom);
    end
    return t;
  endfunction

  // present one request, hold it until taken, then log the expected drive
  task automatic send_tick(input tick_in_t t, input bit typed, input drive_out_t want);
    drive_out_t pred;
    // idle cycles drawn one at a time so the sender rests in about IDLE_PCT of cycles
    if (!no_gaps) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tdata  <= IN_W'({t.speed, t.vc, t.vb, t.va, t.neutral, t.cmd});
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    pred = commutate(t);
    // hand-typed rows are checked against the typed value
    pending_drive.push_back(typed ? want : pred);
  endtask

  // stop sending and let the pipeline empty
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_drive.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 1) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_FULL_DUTY:    full_duty_r  = val;
      CFG_LOW_SPEED:    speed_lim_r  = val;
      CFG_MIN_COMMAND:  min_cmd_r    = val[MINCMD_W-1:0];
      CFG_FORCED_TICKS: step_ticks_r = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_cnt++;
    end
  endtask

  // result side stalls at random except during the no-gap phase
  always @(posedge clk) begin
    out_tready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // compare every accepted result with the oldest expected drive
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_drive.size() == 0) begin
        $error("unexpected result: sector %0d", out_tdata[2:0]);
        mismatch_cnt++;
      end else begin
        want_drive = pending_drive.pop_front();
        check_field("sector_now", want_drive.sector, out_tdata[2:0]);
        check_field("duty_a", want_drive.duty_a, out_tdata[18:3]);
        check_field("duty_b", want_drive.duty_b, out_tdata[34:19]);
        check_field("duty_c", want_drive.duty_c, out_tdata[50:35]);
        check_field("enable_a", want_drive.en_a, out_tdata[51]);
        check_field("enable_b", want_drive.en_b, out_tdata[52]);
        check_field("enable_c", want_drive.en_c, out_tdata[53]);
      end
    end
  end

  // watchdog against a hung handshake
  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    int i;
    int ph;
    int k;
    int run_left;
    bit run_neg;
    bit noise;
    run_left = 0;
    run_neg  = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (i = 0; i < DIR_ROWS; i++) begin
      if (DIR_TABLE[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(DIR_TABLE[i].reg_idx, DIR_TABLE[i].reg_val);
      end else begin
        send_tick(DIR_TABLE[i].tick, DIR_TABLE[i].typed, DIR_TABLE[i].want);
      end
    end

    // random phases, each with its own register setting
    // phase 1 is the wide-open extreme, phase 2 the tight one
    for (ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      write_reg(CFG_FULL_DUTY, (ph == 1) ? 16'hFFFF :
                               (ph == 2) ? 16'h0000 : 16'($urandom));
      write_reg(CFG_LOW_SPEED, (ph == 1) ? 16'hFFFF :
                               (ph == 2) ? 16'h0000 : 16'($urandom));
      write_reg(CFG_MIN_COMMAND, (ph == 1) ? 16'h0000 :
                                 (ph == 2) ? 16'h4000 : 16'($urandom_range(0, 16384)));
      write_reg(CFG_FORCED_TICKS, (ph == 1) ? 16'h0001 :
                                  (ph == 2) ? 16'hFFFF : 16'($urandom_range(1, 32)));
      // one phase runs back to back on both sides
      no_gaps = (ph == 3);
      for (k = 0; k < PHASE_TICKS; k++) begin
        if (run_left == 0) begin
          run_neg  = 1'($urandom_range(0, 1));
          run_left = $urandom_range(4, 40);
        end
        run_left--;
        noise = $urandom_range(0, 99) < 20;
        // mid-phase hold-off until every result is back
        if (ph == 4 && k == PHASE_TICKS / 2) begin
          wait_idle();
        end
        send_tick(random_tick(run_neg, noise), 1'b0, '0);
      end
    end

    wait_idle();
    repeat (PIPE_LAT + 2) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
